// File: hdl/qgap_pkg.sv
// ----------------------------------------------------------------------------
// qgap_pkg
// Shared types and constants for the single-qubit gate amplitude pair block.
// ----------------------------------------------------------------------------
package qgap_pkg;

  localparam int unsigned AmpW     = 16;  // Q1.15 amplitude
  localparam int unsigned OpW      = 17;  // amplitude sum / negation
  localparam int unsigned CoefW    = 18;  // Q2.16 coefficient
  localparam int unsigned ProdW    = OpW + CoefW + 1;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned FracW    = 16;
  localparam int unsigned ShW      = SumW - FracW;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned GateW    = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = CoefW;

  typedef logic signed [AmpW-1:0]  amp_t;
  typedef logic signed [OpW-1:0]   op_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [ShW-1:0]   sh_t;

  // lane order of the result: new_first_re, new_first_im, new_second_re, new_second_im
  localparam int unsigned LaneFirstRe  = 0;
  localparam int unsigned LaneFirstIm  = 1;
  localparam int unsigned LaneSecondRe = 2;
  localparam int unsigned LaneSecondIm = 3;

  localparam coef_t COEF_ONE  = coef_t'(65536);
  localparam coef_t COEF_ZERO = coef_t'(0);
  localparam coef_t COEF_H    = coef_t'(46341);  // 1/sqrt(2)
  localparam op_t   OP_ZERO   = op_t'(0);
  localparam sum_t  RND_BIAS  = sum_t'(32768);
  localparam sh_t   SAT_MAX   = sh_t'(32767);
  localparam sh_t   SAT_MIN   = -sh_t'(32768);
  localparam amp_t  AMP_MAX   = amp_t'(32767);
  localparam amp_t  AMP_MIN   = amp_t'(16'h8000);

  typedef enum logic [GateW-1:0] {
    GATE_HADAMARD = 4'd0,
    GATE_ROT_X    = 4'd1,
    GATE_ROT_Y    = 4'd2,
    GATE_ROT_Z    = 4'd3,
    GATE_PAULI_X  = 4'd4,
    GATE_PAULI_Y  = 4'd5,
    GATE_PAULI_Z  = 4'd6,
    GATE_T        = 4'd7,
    GATE_PHASE    = 4'd8
  } gate_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GATE_KIND = 3'd0,
    CFG_COS_HALF  = 3'd1,
    CFG_SIN_HALF  = 3'd2,
    CFG_PHASE_RE  = 3'd3,
    CFG_PHASE_IM  = 3'd4
  } cfg_idx_t;

  // one output component is c0*x0 + c1*x1
  typedef struct packed {
    coef_t c0;
    op_t   x0;
    coef_t c1;
    op_t   x1;
  } term_t;

  typedef struct packed {
    coef_t cos_half;
    coef_t sin_half;
    coef_t phase_re;
    coef_t phase_im;
  } coefs_t;

endpackage

// File: hdl/qgap_if.sv
// ----------------------------------------------------------------------------
// qgap_if
// Valid/ready channels for amplitude pairs in and gated pairs out.
// ----------------------------------------------------------------------------
interface qgap_in_if;
  logic                valid;
  logic                ready;
  qgap_pkg::amp_t      first_re;
  qgap_pkg::amp_t      first_im;
  qgap_pkg::amp_t      second_re;
  qgap_pkg::amp_t      second_im;

  modport source (output valid, first_re, first_im, second_re, second_im, input ready);
  modport sink   (input valid, first_re, first_im, second_re, second_im, output ready);
endinterface

interface qgap_out_if;
  logic                valid;
  logic                ready;
  qgap_pkg::amp_t      new_first_re;
  qgap_pkg::amp_t      new_first_im;
  qgap_pkg::amp_t      new_second_re;
  qgap_pkg::amp_t      new_second_im;
  logic                clipped;

  modport source (output valid, new_first_re, new_first_im, new_second_re, new_second_im,
                  clipped, input ready);
  modport sink   (input valid, new_first_re, new_first_im, new_second_re, new_second_im,
                  clipped, output ready);
endinterface

// File: hdl/qubit_gate_amplitude_pair_top.sv
// ----------------------------------------------------------------------------
// qubit_gate_amplitude_pair_top
// Applies a configurable single-qubit 2x2 gate to a pair of Q1.15 amplitudes.
// ----------------------------------------------------------------------------
// Usage:
//   in_pair takes one beat per amplitude pair (first = target bit zero,
//   second = target bit one); out_pair returns the gated pair plus clipped,
//   set when any component saturated. Both are valid/ready channels.
//   The cfg_ port writes gate_kind, cos_half, sin_half, phase_re, phase_im
//   (index 0..4, higher indexes ignored); write only while the pipe is empty.
//   From input beat to output beat a pair passes gate decode, the
//   eight 18x17 multipliers, the lane add with rounding bias, and the clamp
//   into the output register. One pair enters every cycle unless the sink stalls.
//   Reset empties all four stages and loads the config defaults (hadamard,
//   cos_half 1.0, sin_half 0, phase 1.0 + 0i).
//   When out_pair.ready is low, stages keep filling bubbles ahead of the
//   stalled beat; in_pair.ready drops only once every stage holds a beat.
// ----------------------------------------------------------------------------
module qubit_gate_amplitude_pair_top (
  input  logic                              clk,
  input  logic                              rst_n,
  qgap_in_if.sink                           in_pair,
  qgap_out_if.source                        out_pair,
  input  logic                              cfg_we,
  input  logic [qgap_pkg::CfgIdxW-1:0]      cfg_idx,
  input  logic [qgap_pkg::CfgDataW-1:0]     cfg_data
);

  logic [qgap_pkg::GateW-1:0] gate_kind_r;
  qgap_pkg::coefs_t           coefs_r;

  logic sel_valid, sel_ready, mac_valid, mac_ready;
  qgap_pkg::term_t [qgap_pkg::NumLanes-1:0] terms;
  qgap_pkg::sum_t  [qgap_pkg::NumLanes-1:0] sums;
  qgap_pkg::amp_t  [qgap_pkg::NumLanes-1:0] amps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_kind_r      <= qgap_pkg::GATE_HADAMARD;
      coefs_r.cos_half <= qgap_pkg::COEF_ONE;
      coefs_r.sin_half <= qgap_pkg::COEF_ZERO;
      coefs_r.phase_re <= qgap_pkg::COEF_ONE;
      coefs_r.phase_im <= qgap_pkg::COEF_ZERO;
    end else if (cfg_we) begin
      case (cfg_idx)
        qgap_pkg::CFG_GATE_KIND: gate_kind_r      <= cfg_data[qgap_pkg::GateW-1:0];
        qgap_pkg::CFG_COS_HALF:  coefs_r.cos_half <= cfg_data;
        qgap_pkg::CFG_SIN_HALF:  coefs_r.sin_half <= cfg_data;
        qgap_pkg::CFG_PHASE_RE:  coefs_r.phase_re <= cfg_data;
        qgap_pkg::CFG_PHASE_IM:  coefs_r.phase_im <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  qgap_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (in_pair.valid),
    .ready_o   (in_pair.ready),
    .first_re  (in_pair.first_re),
    .first_im  (in_pair.first_im),
    .second_re (in_pair.second_re),
    .second_im (in_pair.second_im),
    .gate_kind (gate_kind_r),
    .coefs     (coefs_r),
    .valid_o   (sel_valid),
    .ready_i   (sel_ready),
    .terms_o   (terms)
  );

  qgap_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (sel_valid),
    .ready_o (sel_ready),
    .terms_i (terms),
    .valid_o (mac_valid),
    .ready_i (mac_ready),
    .sums_o  (sums)
  );

  qgap_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (mac_valid),
    .ready_o   (mac_ready),
    .sums_i    (sums),
    .valid_o   (out_pair.valid),
    .ready_i   (out_pair.ready),
    .amps_o    (amps),
    .clipped_o (out_pair.clipped)
  );

  assign out_pair.new_first_re  = amps[qgap_pkg::LaneFirstRe];
  assign out_pair.new_first_im  = amps[qgap_pkg::LaneFirstIm];
  assign out_pair.new_second_re = amps[qgap_pkg::LaneSecondRe];
  assign out_pair.new_second_im = amps[qgap_pkg::LaneSecondIm];

endmodule

// File: hdl/qgap_select.sv
// ----------------------------------------------------------------------------
// qgap_select
// Stage 1: decodes the gate into two coefficient/operand pairs per lane.
// ----------------------------------------------------------------------------
module qgap_select (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           valid_i,
  output logic                                           ready_o,
  input  qgap_pkg::amp_t                                 first_re,
  input  qgap_pkg::amp_t                                 first_im,
  input  qgap_pkg::amp_t                                 second_re,
  input  qgap_pkg::amp_t                                 second_im,
  input  logic [qgap_pkg::GateW-1:0]                     gate_kind,
  input  qgap_pkg::coefs_t                               coefs,
  output logic                                           valid_o,
  input  logic                                           ready_i,
  output qgap_pkg::term_t [qgap_pkg::NumLanes-1:0]       terms_o
);

  function automatic qgap_pkg::term_t mk(qgap_pkg::coef_t c0, qgap_pkg::op_t x0,
                                         qgap_pkg::coef_t c1, qgap_pkg::op_t x1);
    qgap_pkg::term_t t;
    t.c0 = c0;
    t.x0 = x0;
    t.c1 = c1;
    t.x1 = x1;
    return t;
  endfunction

  qgap_pkg::op_t   ar, ai, br, bi;
  qgap_pkg::coef_t c, s;
  qgap_pkg::term_t [qgap_pkg::NumLanes-1:0] terms_nxt;
  qgap_pkg::term_t [qgap_pkg::NumLanes-1:0] terms_r;
  logic valid_r, valid_nxt, adv;

  assign ar = {first_re[qgap_pkg::AmpW-1], first_re};
  assign ai = {first_im[qgap_pkg::AmpW-1], first_im};
  assign br = {second_re[qgap_pkg::AmpW-1], second_re};
  assign bi = {second_im[qgap_pkg::AmpW-1], second_im};
  assign c  = coefs.cos_half;
  assign s  = coefs.sin_half;

  always_comb begin
    // untouched components pass as x * 1.0
    terms_nxt[qgap_pkg::LaneFirstRe]  = mk(qgap_pkg::COEF_ONE, ar, qgap_pkg::COEF_ZERO,
                                           qgap_pkg::OP_ZERO);
    terms_nxt[qgap_pkg::LaneFirstIm]  = mk(qgap_pkg::COEF_ONE, ai, qgap_pkg::COEF_ZERO,
                                           qgap_pkg::OP_ZERO);
    terms_nxt[qgap_pkg::LaneSecondRe] = mk(qgap_pkg::COEF_ONE, br, qgap_pkg::COEF_ZERO,
                                           qgap_pkg::OP_ZERO);
    terms_nxt[qgap_pkg::LaneSecondIm] = mk(qgap_pkg::COEF_ONE, bi, qgap_pkg::COEF_ZERO,
                                           qgap_pkg::OP_ZERO);
    case (gate_kind)
      qgap_pkg::GATE_HADAMARD: begin
        terms_nxt[qgap_pkg::LaneFirstRe]  = mk(qgap_pkg::COEF_H, ar + br, qgap_pkg::COEF_ZERO,
                                               qgap_pkg::OP_ZERO);
        terms_nxt[qgap_pkg::LaneFirstIm]  = mk(qgap_pkg::COEF_H, ai + bi, qgap_pkg::COEF_ZERO,
                                               qgap_pkg::OP_ZERO);
        terms_nxt[qgap_pkg::LaneSecondRe] = mk(qgap_pkg::COEF_H, ar - br, qgap_pkg::COEF_ZERO,
                                               qgap_pkg::OP_ZERO);
        terms_nxt[qgap_pkg::LaneSecondIm] = mk(qgap_pkg::COEF_H, ai - bi, qgap_pkg::COEF_ZERO,
                                               qgap_pkg::OP_ZERO);
      end
      // the operand is negated rather than the raw sine register
      qgap_pkg::GATE_ROT_X: begin
        terms_nxt[qgap_pkg::LaneFirstRe]  = mk(c, ar, s, bi);
        terms_nxt[qgap_pkg::LaneFirstIm]  = mk(c, ai, s, -br);
        terms_nxt[qgap_pkg::LaneSecondRe] = mk(s, ai, c, br);
        terms_nxt[qgap_pkg::LaneSecondIm] = mk(c, bi, s, -ar);
      end
      qgap_pkg::GATE_ROT_Y: begin
        terms_nxt[qgap_pkg::LaneFirstRe]  = mk(c, ar, s, -br);
        terms_nxt[qgap_pkg::LaneFirstIm]  = mk(c, ai, s, -bi);
        terms_nxt[qgap_pkg::LaneSecondRe] = mk(s, ar, c, br);
        terms_nxt[qgap_pkg::LaneSecondIm] = mk(s, ai, c, bi);
      end
      qgap_pkg::GATE_ROT_Z: begin
        terms_nxt[qgap_pkg::LaneFirstRe]  = mk(c, ar, s, ai);
        terms_nxt[qgap_pkg::LaneFirstIm]  = mk(c, ai, s, -ar);
        terms_nxt[qgap_pkg::LaneSecondRe] = mk(c, br, s, -bi);
        terms_nxt[qgap_pkg::LaneSecondIm] = mk(c, bi, s, br);
      end
      qgap_pkg::GATE_PAULI_X: begin
        terms_nxt[qgap_pkg::LaneFirstRe].x0  = br;
        terms_nxt[qgap_pkg::LaneFirstIm].x0  = bi;
        terms_nxt[qgap_pkg::LaneSecondRe].x0 = ar;
        terms_nxt[qgap_pkg::LaneSecondIm].x0 = ai;
      end
      qgap_pkg::GATE_PAULI_Y: begin
        terms_nxt[qgap_pkg::LaneFirstRe].x0  = bi;
        terms_nxt[qgap_pkg::LaneFirstIm].x0  = -br;
        terms_nxt[qgap_pkg::LaneSecondRe].x0 = -ai;
        terms_nxt[qgap_pkg::LaneSecondIm].x0 = ar;
      end
      qgap_pkg::GATE_PAULI_Z: begin
        terms_nxt[qgap_pkg::LaneSecondRe].x0 = -br;
        terms_nxt[qgap_pkg::LaneSecondIm].x0 = -bi;
      end
      qgap_pkg::GATE_T: begin
        terms_nxt[qgap_pkg::LaneSecondRe] = mk(qgap_pkg::COEF_H, br - bi, qgap_pkg::COEF_ZERO,
                                               qgap_pkg::OP_ZERO);
        terms_nxt[qgap_pkg::LaneSecondIm] = mk(qgap_pkg::COEF_H, br + bi, qgap_pkg::COEF_ZERO,
                                               qgap_pkg::OP_ZERO);
      end
      qgap_pkg::GATE_PHASE: begin
        terms_nxt[qgap_pkg::LaneSecondRe] = mk(coefs.phase_re, br, coefs.phase_im, -bi);
        terms_nxt[qgap_pkg::LaneSecondIm] = mk(coefs.phase_re, bi, coefs.phase_im, br);
      end
      default: begin
      end
    endcase
  end

  assign adv       = ready_i || !valid_r;
  assign ready_o   = adv;
  assign valid_nxt = adv ? valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      terms_r <= terms_nxt;
    end
  end

  assign valid_o = valid_r;
  assign terms_o = terms_r;

endmodule

// File: hdl/qgap_mac.sv
// ----------------------------------------------------------------------------
// qgap_mac
// Stages 2 and 3: registered products, then the lane sum with rounding bias.
// ----------------------------------------------------------------------------
module qgap_mac (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  qgap_pkg::term_t [qgap_pkg::NumLanes-1:0]  terms_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output qgap_pkg::sum_t  [qgap_pkg::NumLanes-1:0]  sums_o
);

  qgap_pkg::prod_t [qgap_pkg::NumLanes-1:0] p0_nxt, p1_nxt, p0_r, p1_r;
  qgap_pkg::sum_t  [qgap_pkg::NumLanes-1:0] sum_nxt, sum_r;
  logic valid_p_r, valid_p_nxt, valid_s_r, valid_s_nxt;
  logic adv_p, adv_s;

  always_comb begin
    for (int l = 0; l < qgap_pkg::NumLanes; l++) begin
      p0_nxt[l]  = terms_i[l].c0 * terms_i[l].x0;
      p1_nxt[l]  = terms_i[l].c1 * terms_i[l].x1;
      sum_nxt[l] = qgap_pkg::sum_t'(p0_r[l]) + qgap_pkg::sum_t'(p1_r[l]) + qgap_pkg::RND_BIAS;
    end
  end

  assign adv_s       = ready_i || !valid_s_r;
  assign adv_p       = adv_s || !valid_p_r;
  assign ready_o     = adv_p;
  assign valid_p_nxt = adv_p ? valid_i : valid_p_r;
  assign valid_s_nxt = adv_s ? valid_p_r : valid_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_p_r <= 1'b0;
      valid_s_r <= 1'b0;
    end else begin
      valid_p_r <= valid_p_nxt;
      valid_s_r <= valid_s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_p && valid_i) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
    end
    if (adv_s && valid_p_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign valid_o = valid_s_r;
  assign sums_o  = sum_r;

endmodule

// File: hdl/qgap_sat.sv
// ----------------------------------------------------------------------------
// qgap_sat
// Stage 4: drops the fraction, clamps to 16 bits and holds the output beat.
// ----------------------------------------------------------------------------
module qgap_sat (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  qgap_pkg::sum_t [qgap_pkg::NumLanes-1:0]   sums_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output qgap_pkg::amp_t [qgap_pkg::NumLanes-1:0]   amps_o,
  output logic                                      clipped_o
);

  qgap_pkg::amp_t [qgap_pkg::NumLanes-1:0] amp_nxt, amp_r;
  qgap_pkg::sh_t   sh;
  logic clip_nxt, clip_r, valid_r, valid_nxt, adv;

  always_comb begin
    clip_nxt = 1'b0;
    sh       = '0;
    for (int l = 0; l < qgap_pkg::NumLanes; l++) begin
      // floor by 2^16 after the bias gives round half up
      sh = sums_i[l][qgap_pkg::SumW-1:qgap_pkg::FracW];
      if (sh > qgap_pkg::SAT_MAX) begin
        amp_nxt[l] = qgap_pkg::AMP_MAX;
        clip_nxt   = 1'b1;
      end else if (sh < qgap_pkg::SAT_MIN) begin
        amp_nxt[l] = qgap_pkg::AMP_MIN;
        clip_nxt   = 1'b1;
      end else begin
        amp_nxt[l] = sh[qgap_pkg::AmpW-1:0];
      end
    end
  end

  assign adv       = ready_i || !valid_r;
  assign ready_o   = adv;
  assign valid_nxt = adv ? valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      amp_r  <= amp_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign valid_o   = valid_r;
  assign amps_o    = amp_r;
  assign clipped_o = clip_r;

endmodule

// File: hdl/qgap_chk.sv
// ----------------------------------------------------------------------------
// qgap_chk
// Port-level checks on the amplitude pair block, bound to the top level.
// ----------------------------------------------------------------------------
module qgap_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input qgap_pkg::amp_t new_first_re,
  input qgap_pkg::amp_t new_first_im,
  input qgap_pkg::amp_t new_second_re,
  input qgap_pkg::amp_t new_second_im,
  input logic           clipped
);

  // held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(new_first_re) &&
      $stable(new_first_im) && $stable(new_second_re) && $stable(new_second_im) &&
      $stable(clipped))
    else $error("output beat changed while stalled");

  // a free-running sink never backs up the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // clipped only with a component pinned at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |->
      new_first_re == qgap_pkg::AMP_MAX || new_first_re == qgap_pkg::AMP_MIN ||
      new_first_im == qgap_pkg::AMP_MAX || new_first_im == qgap_pkg::AMP_MIN ||
      new_second_re == qgap_pkg::AMP_MAX || new_second_re == qgap_pkg::AMP_MIN ||
      new_second_im == qgap_pkg::AMP_MAX || new_second_im == qgap_pkg::AMP_MIN)
    else $error("clipped without a saturated component");

  // reset leaves no beat in flight
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind qubit_gate_amplitude_pair_top qgap_chk u_qgap_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_pair.ready),
  .out_valid     (out_pair.valid),
  .out_ready     (out_pair.ready),
  .new_first_re  (out_pair.new_first_re),
  .new_first_im  (out_pair.new_first_im),
  .new_second_re (out_pair.new_second_re),
  .new_second_im (out_pair.new_second_im),
  .clipped       (out_pair.clipped)
);

// File: test/qgap_pair_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgap_pair_checker
// Follows the config port and both pair channels, works out the gated pair
// for every input beat and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
module qgap_pair_checker
  import qgap_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  qgap_in_if                  in_pair,
  qgap_out_if                 out_pair,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  result_count,
  output int                  clip_count
);

  typedef struct packed {
    amp_t first_re;
    amp_t first_im;
    amp_t second_re;
    amp_t second_im;
    logic clipped;
  } gated_pair_t;

  gated_pair_t      gated_q[$];
  logic [GateW-1:0] gate_sel;
  longint           cos_h;
  longint           sin_h;
  longint           ph_re;
  longint           ph_im;

  // floor((x + 2^15) / 2^16): ties go toward plus infinity
  function automatic longint round_q16(input longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic gated_pair_t apply_gate(input amp_t fr, input amp_t fi,
                                             input amp_t sr, input amp_t si);
    longint      ar, ai, br, bi, c, s, h;
    longint      lane [NumLanes];
    gated_pair_t res;
    ar = fr;
    ai = fi;
    br = sr;
    bi = si;
    c  = cos_h;
    s  = sin_h;
    h  = COEF_H;
    lane[LaneFirstRe]  = ar;
    lane[LaneFirstIm]  = ai;
    lane[LaneSecondRe] = br;
    lane[LaneSecondIm] = bi;
    case (gate_sel)
      GATE_HADAMARD: begin
        lane[LaneFirstRe]  = round_q16((ar + br) * h);
        lane[LaneFirstIm]  = round_q16((ai + bi) * h);
        lane[LaneSecondRe] = round_q16((ar - br) * h);
        lane[LaneSecondIm] = round_q16((ai - bi) * h);
      end
      GATE_ROT_X: begin
        lane[LaneFirstRe]  = round_q16(c * ar + s * bi);
        lane[LaneFirstIm]  = round_q16(c * ai - s * br);
        lane[LaneSecondRe] = round_q16(s * ai + c * br);
        lane[LaneSecondIm] = round_q16(c * bi - s * ar);
      end
      GATE_ROT_Y: begin
        lane[LaneFirstRe]  = round_q16(c * ar - s * br);
        lane[LaneFirstIm]  = round_q16(c * ai - s * bi);
        lane[LaneSecondRe] = round_q16(s * ar + c * br);
        lane[LaneSecondIm] = round_q16(s * ai + c * bi);
      end
      GATE_ROT_Z: begin
        lane[LaneFirstRe]  = round_q16(c * ar + s * ai);
        lane[LaneFirstIm]  = round_q16(c * ai - s * ar);
        lane[LaneSecondRe] = round_q16(c * br - s * bi);
        lane[LaneSecondIm] = round_q16(c * bi + s * br);
      end
      GATE_PAULI_X: begin
        lane[LaneFirstRe]  = br;
        lane[LaneFirstIm]  = bi;
        lane[LaneSecondRe] = ar;
        lane[LaneSecondIm] = ai;
      end
      GATE_PAULI_Y: begin
        lane[LaneFirstRe]  = bi;
        lane[LaneFirstIm]  = -br;
        lane[LaneSecondRe] = -ai;
        lane[LaneSecondIm] = ar;
      end
      GATE_PAULI_Z: begin
        lane[LaneSecondRe] = -br;
        lane[LaneSecondIm] = -bi;
      end
      GATE_T: begin
        lane[LaneSecondRe] = round_q16(h * (br - bi));
        lane[LaneSecondIm] = round_q16(h * (br + bi));
      end
      GATE_PHASE: begin
        lane[LaneSecondRe] = round_q16(ph_re * br - ph_im * bi);
        lane[LaneSecondIm] = round_q16(ph_re * bi + ph_im * br);
      end
      default: ;  // unused codes pass the pair through
    endcase
    res.clipped = 1'b0;
    foreach (lane[k]) begin
      if (lane[k] > AMP_MAX) begin
        lane[k]     = AMP_MAX;
        res.clipped = 1'b1;
      end else if (lane[k] < AMP_MIN) begin
        lane[k]     = AMP_MIN;
        res.clipped = 1'b1;
      end
    end
    res.first_re  = amp_t'(lane[LaneFirstRe]);
    res.first_im  = amp_t'(lane[LaneFirstIm]);
    res.second_re = amp_t'(lane[LaneSecondRe]);
    res.second_im = amp_t'(lane[LaneSecondIm]);
    return res;
  endfunction

  task automatic compare_field(input string field, input amp_t want, input amp_t got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    gated_pair_t want, got;
    if (!rst_n) begin
      gated_q.delete();
      gate_sel = GATE_HADAMARD;
      cos_h    = COEF_ONE;
      sin_h    = COEF_ZERO;
      ph_re    = COEF_ONE;
      ph_im    = COEF_ZERO;
    end else begin
      if (out_pair.valid && out_pair.ready) begin
        got = '{out_pair.new_first_re, out_pair.new_first_im, out_pair.new_second_re,
                out_pair.new_second_im, out_pair.clipped};
        result_count++;
        if (got.clipped === 1'b1) begin
          clip_count++;
        end
        if (gated_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with no pair outstanding, expected none, got %0d %0d %0d %0d",
                   $time, got.first_re, got.first_im, got.second_re, got.second_im);
        end else begin
          want = gated_q.pop_front();
          compare_field("new_first_re", want.first_re, got.first_re);
          compare_field("new_first_im", want.first_im, got.first_im);
          compare_field("new_second_re", want.second_re, got.second_re);
          compare_field("new_second_im", want.second_im, got.second_im);
          compare_field("clipped", amp_t'(want.clipped), amp_t'(got.clipped));
        end
      end
      // prediction uses the settings in force before any write at this edge
      if (in_pair.valid && in_pair.ready) begin
        gated_q.push_back(apply_gate(in_pair.first_re, in_pair.first_im,
                                     in_pair.second_re, in_pair.second_im));
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GATE_KIND: gate_sel = cfg_data[GateW-1:0];
          CFG_COS_HALF:  cos_h    = coef_t'(cfg_data);
          CFG_SIN_HALF:  sin_h    = coef_t'(cfg_data);
          CFG_PHASE_RE:  ph_re    = coef_t'(cfg_data);
          CFG_PHASE_IM:  ph_im    = coef_t'(cfg_data);
          default: ;
        endcase
      end
    end
    pending = gated_q.size();
  end

endmodule

// File: test/qubit_gate_amplitude_pair_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qubit_gate_amplitude_pair_top_tb
// Corner pairs under the reset gate, both Pauli negations and a rounding-tie
// rotation, then random pairs across all defined gate codes and some unused
// ones, with random and extreme coefficients, under varying source gaps and sink stalls.
// ----------------------------------------------------------------------------
module qubit_gate_amplitude_pair_top_tb;
  import qgap_pkg::*;

  localparam int    PipeDepth     = 4;
  localparam int    WatchdogLimit = 3000;
  localparam int    NumPhases     = 30;
  localparam int    HoldOffCycles = 400;
  localparam int    HoldOffPhase  = 6;
  localparam int    PausePhase    = 11;
  localparam int    NumCorners    = 6;
  localparam coef_t COEF_HALF     = coef_t'(32768);

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  qgap_in_if  in_pair ();
  qgap_out_if out_pair ();

  int fail_count;
  int pending;
  int result_count;
  int clip_count;
  int send_idle_pct;
  int sink_stall_pct;
  int holds_asked;
  int pairs_sent;
  int settings_run;

  amp_t corner [NumCorners][NumLanes];

  qubit_gate_amplitude_pair_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pair  (in_pair),
    .out_pair (out_pair),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  qgap_pair_checker pair_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_pair      (in_pair),
    .out_pair     (out_pair),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .clip_count   (clip_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink side: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int holds_done;
    int left;
    holds_done = 0;
    left       = 0;
    out_pair.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        left       = HoldOffCycles;
      end
      if (left > 0) begin
        out_pair.ready <= 1'b0;
        left--;
      end else begin
        out_pair.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_pair.valid && in_pair.ready) || (out_pair.valid && out_pair.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
             WatchdogLimit, pending);
    $display("TB_ERROR");
    $finish;
  end

  function automatic amp_t rand_amp();
    case ($urandom_range(7))
      0:       return AMP_MAX;
      1:       return AMP_MIN;
      2:       return '0;
      3:       return amp_t'(int'($urandom_range(8)) - 4);
      default: return amp_t'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_coef();
    case ($urandom_range(11))
      0:       return COEF_ONE;
      1:       return -COEF_ONE;
      2:       return COEF_ZERO;
      3:       return COEF_H;
      4:       return -COEF_H;
      5:       return {1'b0, {(CfgDataW-1){1'b1}}};  // raw max, past +1.0
      6:       return {1'b1, {(CfgDataW-1){1'b0}}};  // raw min, past -1.0
      7:       return CfgDataW'($urandom);
      default: return CfgDataW'(int'($urandom_range(2 * 65536)) - 65536);
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pair(input amp_t fr, input amp_t fi, input amp_t sr, input amp_t si);
    if ($urandom_range(99) < send_idle_pct) begin
      in_pair.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_pair.valid     <= 1'b1;
    in_pair.first_re  <= fr;
    in_pair.first_im  <= fi;
    in_pair.second_re <= sr;
    in_pair.second_im <= si;
    do @(posedge clk); while (!in_pair.ready);
    @(negedge clk);
    pairs_sent++;
  endtask

  task automatic drain_pipe();
    in_pair.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PipeDepth + 2) @(negedge clk);
  endtask

  task automatic send_corners();
    for (int n = 0; n < NumCorners; n++) begin
      send_pair(corner[n][LaneFirstRe], corner[n][LaneFirstIm],
                corner[n][LaneSecondRe], corner[n][LaneSecondIm]);
    end
    drain_pipe();
  endtask

  initial begin
    int               n_items;
    logic [GateW-1:0] gate_code;
    corner = '{'{AMP_MAX, AMP_MAX, AMP_MAX, AMP_MAX},
               '{AMP_MIN, AMP_MIN, AMP_MIN, AMP_MIN},
               '{AMP_MAX, AMP_MIN, AMP_MIN, AMP_MAX},
               '{0, 0, 0, 0},
               '{AMP_MIN, 0, AMP_MIN, 0},
               '{1, 0, -1, 0}};
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_data          <= '0;
    in_pair.valid     <= 1'b0;
    in_pair.first_re  <= '0;
    in_pair.first_im  <= '0;
    in_pair.second_re <= '0;
    in_pair.second_im <= '0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings give the hadamard gate
    send_corners();
    // negating the most negative amplitude must clamp
    write_reg(CFG_GATE_KIND, CfgDataW'(GATE_PAULI_Y));
    send_corners();
    write_reg(CFG_GATE_KIND, CfgDataW'(GATE_PAULI_Z));
    send_corners();
    // half-scale coefficients put exact ties in front of the rounding
    write_reg(CFG_COS_HALF, COEF_HALF);
    write_reg(CFG_SIN_HALF, COEF_HALF);
    write_reg(CFG_GATE_KIND, CfgDataW'(GATE_ROT_Z));
    send_corners();

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin send_idle_pct = 67; sink_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  sink_stall_pct = 67; end
        default: begin send_idle_pct = 6;  sink_stall_pct = 6;  end
      endcase
      if (p % (GATE_PHASE + 2) <= GATE_PHASE) begin
        gate_code = GateW'(p % (GATE_PHASE + 2));
      end else if (p == GATE_PHASE + 1) begin
        gate_code = {GateW{1'b1}};
      end else begin
        gate_code = GateW'($urandom_range((1 << GateW) - 1, GATE_PHASE + 1));
      end
      write_reg(CFG_COS_HALF, rand_coef());
      write_reg(CFG_SIN_HALF, rand_coef());
      write_reg(CFG_PHASE_RE, rand_coef());
      write_reg(CFG_PHASE_IM, rand_coef());
      if (p % 3 == 0) begin
        write_reg(CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, CFG_PHASE_IM + 1)), rand_coef());
      end
      // bits above the gate code should be ignored
      write_reg(CFG_GATE_KIND, {(CfgDataW-GateW)'($urandom), gate_code});
      n_items = $urandom_range(76, 40);
      if (p == HoldOffPhase) begin
        // sink holds off while the source keeps offering, so the pipe backs up
        send_idle_pct = 0;
        holds_asked++;
      end
      for (int k = 0; k < n_items; k++) begin
        if (p == PausePhase && k == n_items / 2) begin
          drain_pipe();
        end
        send_pair(rand_amp(), rand_amp(), rand_amp(), rand_amp());
      end
      drain_pipe();
      settings_run++;
    end

    $display("covered %0d pairs: corner sweeps plus %0d random gate settings, all gate codes",
             pairs_sent, settings_run);
    $display("%0d results checked, %0d of them saturated", result_count, clip_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: qubit_gate_amplitude_pair_top.f
hdl/qgap_pkg.sv
hdl/qgap_if.sv
hdl/qgap_select.sv
hdl/qgap_mac.sv
hdl/qgap_sat.sv
hdl/qubit_gate_amplitude_pair_top.sv
hdl/qgap_chk.sv
test/qgap_pair_checker.sv
test/qubit_gate_amplitude_pair_top_tb.sv
